// File: rtl/battery_monitor_events_macros.svh
// Assertion macros used by the battery monitor top level.
`ifndef BATTERY_MONITOR_EVENTS_MACROS_SVH
`define BATTERY_MONITOR_EVENTS_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BME_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("battery monitor assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BME_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("battery monitor assertion failed");

`endif

// File: rtl/bme_pkg.sv
// Types, constants and the percentage table of the battery monitor.
package bme_pkg;

  typedef enum logic [2:0] {
    EV_CHG_START = 3'd0,
    EV_CHG_STOP  = 3'd1,
    EV_LOW       = 3'd2,
    EV_FULL      = 3'd3,
    EV_STATUS    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CFG_MV_GAIN   = 3'd0,
    CFG_LOW_TH    = 3'd1,
    CFG_LOW_REL   = 3'd2,
    CFG_FULL_TH   = 3'd3,
    CFG_BCAST     = 3'd4
  } cfg_idx_e;

  // One result on its way to the output queue.
  typedef struct packed {
    kind_e       kind;
    logic [12:0] v10;
    logic [7:0]  status;
    logic        last;
  } event_t;

  // One finished round handed from the front end to the event logic.
  typedef struct packed {
    logic        ok;
    logic        chg;
    logic [15:0] mv;
  } round_t;

  localparam int MAX_RESULTS = 3;
  localparam int QDEPTH      = 16;
  localparam int QPTR_W      = 4;
  localparam int QCNT_W      = 5;

  localparam logic [15:0] RST_MV_GAIN   = 16'd57542;
  localparam logic [15:0] RST_LOW_TH    = 16'd3200;
  localparam logic [15:0] RST_LOW_REL   = 16'd3280;
  localparam logic [15:0] RST_FULL_TH   = 16'd4170;
  localparam logic [7:0]  RST_BCAST     = 8'd30;
  localparam logic [15:0] RST_VOLTAGE   = 16'd4000;
  localparam logic [6:0]  RST_PERCENT   = 7'd100;

  // x / 10 is exactly (x * 52429) >> 19 for any 16-bit x.
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam logic [7:0]  CHARGING_FLAG = 8'h80;

  localparam logic [15:0] PCT_MV [10] = '{16'd3620, 16'd3550, 16'd3500, 16'd3450, 16'd3400,
                                          16'd3350, 16'd3300, 16'd3250, 16'd3200, 16'd3000};
  localparam logic [6:0]  PCT_VAL [10] = '{7'd100, 7'd90, 7'd75, 7'd60, 7'd45,
                                           7'd30, 7'd20, 7'd10, 7'd5, 7'd0};

  // First table step whose voltage the input reaches; zero below all steps.
  function automatic logic [6:0] mv_to_percent(input logic [15:0] mv);
    logic [6:0] pct;
    pct = 7'd0;
    for (int i = 9; i >= 0; i--) begin
      if (mv >= PCT_MV[i]) begin
        pct = PCT_VAL[i];
      end
    end
    return pct;
  endfunction

endpackage

// File: rtl/battery_monitor_events.sv
// Battery monitor top level: configuration, round-end event logic and output queue.
// Path: a round-ending sample passes the mean stage and the gain multiply stage, then the
// event logic writes its results into the queue, whose head drives the master side.
// Throughput: one sample per cycle; results leave one per cycle while m_axis_tready is high.
// tready drops unless the 16-entry queue has room for three results per round in flight and the next sample.
// Reset: asynchronous, active low; control state and configuration return to defaults, not the data path.
module battery_monitor_events #(
  parameter int SAMPLES_PER_ROUND = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Sample requests. tdata: [11:0] adc_sample, [12] sample_ok, [13] chg_pin_n, [15:14] zero.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  // Result requests. tdata: [12:0] voltage_10mv, [20:13] status_byte, [23:21] zero.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  // tuser: [2:0] event_kind.
  output logic [2:0]  m_axis_tuser,
  // tlast: last_event.
  output logic        m_axis_tlast,
  // Configuration write requests.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers.
  logic [15:0] mv_gain_q, low_th_q, low_rel_q, full_th_q;
  logic [7:0]  bcast_q;

  // Monitor state updated at each round end.
  logic [15:0] voltage_q;
  logic [6:0]  percent_q;
  logic        charging_q, low_q, full_q;
  logic [7:0]  round_q;

  logic            in_accept;
  logic            rv;
  bme_pkg::round_t rnd;
  logic [1:0]      inflight;

  logic [bme_pkg::QCNT_W-1:0] q_count;
  bme_pkg::event_t            q_head;
  logic                       pop;

  // Event logic signals.
  logic [15:0] v_mv;
  logic [6:0]  pct;
  logic [31:0] div_prod;
  logic [12:0] v10;
  logic        chg_start, chg_stop, low_cond, low_ev, full_cond, full_ev, bcast;
  logic        full_arm, low_next;
  logic [7:0]  rc_inc;
  logic        cand_v [bme_pkg::MAX_RESULTS];
  bme_pkg::event_t cand [bme_pkg::MAX_RESULTS];
  bme_pkg::event_t slot [bme_pkg::MAX_RESULTS];
  logic [1:0]  push_n;
  logic [6:0]  room_need;

  // Every round in flight may still produce three results; hold off new samples unless the
  // queue can take those plus three more for the sample about to enter.
  assign room_need     = 7'(q_count) + 7'(bme_pkg::MAX_RESULTS) * (7'(inflight) + 7'd1);
  assign s_axis_tready = (room_need <= 7'(bme_pkg::QDEPTH));
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  bme_front #(
    .SAMPLES_PER_ROUND(SAMPLES_PER_ROUND)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .sample_i     (s_axis_tdata[11:0]),
    .ok_i         (s_axis_tdata[12]),
    .chg_i        (!s_axis_tdata[13]),
    .gain_i       (mv_gain_q),
    .round_valid_o(rv),
    .round_o      (rnd),
    .inflight_o   (inflight)
  );

  always_comb begin
    // A failed sample keeps the previous voltage and percentage.
    v_mv     = rnd.ok ? rnd.mv : voltage_q;
    pct      = rnd.ok ? bme_pkg::mv_to_percent(rnd.mv) : percent_q;
    div_prod = 32'(v_mv) * 32'(bme_pkg::DIV10_MUL);
    v10      = 13'(div_prod >> bme_pkg::DIV10_SHIFT);

    chg_start = rnd.chg && !charging_q;
    chg_stop  = !rnd.chg && charging_q;
    // Charging start re-arms the full-charge event.
    full_arm  = chg_start ? 1'b0 : full_q;

    // Low battery fires once; it re-arms only above the release level.
    low_cond = !rnd.chg && (v_mv <= low_th_q);
    low_ev   = low_cond && !low_q;
    if (low_cond) begin
      low_next = 1'b1;
    end else if (v_mv > low_rel_q) begin
      low_next = 1'b0;
    end else begin
      low_next = low_q;
    end

    full_cond = rnd.chg && (v_mv >= full_th_q);
    full_ev   = full_cond && !full_arm;

    // A zero or lowered broadcast period makes the compare true at once.
    rc_inc = round_q + 8'd1;
    bcast  = (rc_inc >= bcast_q) || (rc_inc == 8'd0);

    cand_v[0]      = chg_start || chg_stop;
    cand[0].kind   = chg_start ? bme_pkg::EV_CHG_START : bme_pkg::EV_CHG_STOP;
    cand[0].v10    = '0;
    cand[0].status = '0;
    cand[0].last   = !(low_ev || full_ev) && !bcast;

    cand_v[1]      = low_ev || full_ev;
    cand[1].kind   = low_ev ? bme_pkg::EV_LOW : bme_pkg::EV_FULL;
    cand[1].v10    = v10;
    cand[1].status = {1'b0, pct};
    cand[1].last   = !bcast;

    cand_v[2]      = bcast;
    cand[2].kind   = bme_pkg::EV_STATUS;
    cand[2].v10    = v10;
    cand[2].status = {1'b0, pct} | (rnd.chg ? bme_pkg::CHARGING_FLAG : 8'h00);
    cand[2].last   = 1'b1;

    // Pack the events that fire into consecutive queue slots, keeping their order.
    push_n = 2'd0;
    for (int k = 0; k < bme_pkg::MAX_RESULTS; k++) begin
      slot[k] = cand[k];
    end
    for (int k = 0; k < bme_pkg::MAX_RESULTS; k++) begin
      if (cand_v[k]) begin
        slot[push_n] = cand[k];
        push_n       = push_n + 2'd1;
      end
    end
    if (!rv) begin
      push_n = 2'd0;
    end
  end

  bme_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (push_n),
    .push_data_i(slot),
    .pop_i      (pop),
    .count_o    (q_count),
    .head_o     (q_head)
  );

  assign m_axis_tvalid = (q_count != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {3'b000, q_head.status, q_head.v10};
  assign m_axis_tuser  = q_head.kind;
  assign m_axis_tlast  = q_head.last;

  // Configuration writes; indexes beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_gain_q <= bme_pkg::RST_MV_GAIN;
      low_th_q  <= bme_pkg::RST_LOW_TH;
      low_rel_q <= bme_pkg::RST_LOW_REL;
      full_th_q <= bme_pkg::RST_FULL_TH;
      bcast_q   <= bme_pkg::RST_BCAST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (bme_pkg::cfg_idx_e'(cfg_index_i))
        bme_pkg::CFG_MV_GAIN: mv_gain_q <= cfg_data_i;
        bme_pkg::CFG_LOW_TH:  low_th_q  <= cfg_data_i;
        bme_pkg::CFG_LOW_REL: low_rel_q <= cfg_data_i;
        bme_pkg::CFG_FULL_TH: full_th_q <= cfg_data_i;
        bme_pkg::CFG_BCAST:   bcast_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Round-end state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voltage_q  <= bme_pkg::RST_VOLTAGE;
      percent_q  <= bme_pkg::RST_PERCENT;
      charging_q <= 1'b0;
      low_q      <= 1'b0;
      full_q     <= 1'b0;
      round_q    <= '0;
    end else if (rv) begin
      voltage_q  <= v_mv;
      percent_q  <= pct;
      charging_q <= rnd.chg;
      low_q      <= low_next;
      full_q     <= full_arm || full_ev;
      round_q    <= bcast ? 8'd0 : rc_inc;
    end
  end

`include "battery_monitor_events_macros.svh"

  // The queue never holds more than its depth.
  `BME_ASSERT_IMPL(a_no_overflow, 1'b1, q_count <= bme_pkg::QCNT_W'(bme_pkg::QDEPTH))
  // A broadcast restarts the round counter.
  `BME_ASSERT_NEXT(a_bcast_clears, rv && bcast, round_q == 8'd0)
  // A low-battery event leaves the event disarmed.
  `BME_ASSERT_NEXT(a_low_disarms, rv && low_ev, low_q)
  // The status broadcast is always the last result of its round.
  `BME_ASSERT_IMPL(a_status_last, m_axis_tvalid && (m_axis_tuser == bme_pkg::EV_STATUS), m_axis_tlast)

endmodule

// File: rtl/bme_front.sv
// Sample accumulation, round mean and millivolt conversion pipeline.
module bme_front #(
  parameter int SAMPLES_PER_ROUND = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [11:0]     sample_i,
  input  logic            ok_i,
  input  logic            chg_i,
  input  logic [15:0]     gain_i,
  output logic            round_valid_o,
  output bme_pkg::round_t round_o,
  output logic [1:0]      inflight_o
);

  localparam int SUM_W   = $clog2(SAMPLES_PER_ROUND * 4095 + 1);
  localparam int CNT_W   = $clog2(SAMPLES_PER_ROUND + 1);
  localparam int LOG_D   = $clog2(SAMPLES_PER_ROUND);
  localparam int SHIFT   = SUM_W + LOG_D;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam int RECIP   = ((1 << SHIFT) + SAMPLES_PER_ROUND - 1) / SAMPLES_PER_ROUND;

  logic [SUM_W-1:0]  sum_q, sum_d, total;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic              round_full, round_end;
  logic [PROD_W-1:0] mean_prod;
  logic [11:0]       mean;

  logic              s1_valid_q;
  logic              s1_ok_q, s1_chg_q;
  logic [11:0]       s1_mean_q;
  logic              s2_valid_q;
  bme_pkg::round_t   s2_q;
  logic [27:0]       mv_prod;

  always_comb begin
    total      = sum_q + SUM_W'(sample_i);
    cnt_inc    = cnt_q + CNT_W'(1);
    round_full = (cnt_inc == CNT_W'(SAMPLES_PER_ROUND));
    round_end  = !ok_i || round_full;
    // Division by the round length as a multiply by its rounded-up reciprocal.
    mean_prod  = PROD_W'(total) * PROD_W'(RECIP);
    mean       = 12'(mean_prod >> SHIFT);
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    if (accept_i) begin
      if (round_end) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = total;
        cnt_d = cnt_inc;
      end
    end
    mv_prod = 28'(s1_mean_q) * 28'(gain_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
      s1_valid_q <= accept_i && round_end;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_ok_q   <= ok_i;
      s1_chg_q  <= chg_i;
      s1_mean_q <= mean;
    end
    if (s1_valid_q) begin
      s2_q.ok  <= s1_ok_q;
      s2_q.chg <= s1_chg_q;
      s2_q.mv  <= 16'(mv_prod >> 12);
    end
  end

  assign round_valid_o = s2_valid_q;
  assign round_o       = s2_q;
  assign inflight_o    = {1'b0, s1_valid_q} + {1'b0, s2_valid_q};

endmodule

// File: rtl/bme_queue.sv
// Result queue that takes up to three results per cycle and gives one per cycle when popped.
module bme_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_n_i,
  input  bme_pkg::event_t            push_data_i [bme_pkg::MAX_RESULTS],
  input  logic                       pop_i,
  output logic [bme_pkg::QCNT_W-1:0] count_o,
  output bme_pkg::event_t            head_o
);

  bme_pkg::event_t             mem_q [bme_pkg::QDEPTH];
  logic [bme_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [bme_pkg::QCNT_W-1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + bme_pkg::QPTR_W'(push_n_i);
      rd_ptr_q <= rd_ptr_q + bme_pkg::QPTR_W'(pop_i);
      count_q  <= count_q + bme_pkg::QCNT_W'(push_n_i) - bme_pkg::QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < bme_pkg::MAX_RESULTS; k++) begin
      if (2'(k) < push_n_i) begin
        mem_q[wr_ptr_q + bme_pkg::QPTR_W'(k)] <= push_data_i[k];
      end
    end
  end

  assign count_o = count_q;
  assign head_o  = mem_q[rd_ptr_q];

endmodule
